FILE: rtl/lrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrl_pkg
// Shared types and constants of the luma rise rate limiter.
// ----------------------------------------------------------------------------
package lrl_pkg;

   // Rec.601 luma weights, Q0.16
   localparam logic [15:0] W_RED   = 16'd19595;
   localparam logic [15:0] W_GREEN = 16'd38470;
   localparam logic [15:0] W_BLUE  = 16'd7471;
   localparam logic [32:0] LUMA_ROUND = 33'd32768;

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam int TIME_W   = 24;
   localparam int DT_W     = 20;
   localparam int COLOR_W  = 16;
   localparam int SCALE_W  = 17;
   localparam int MEAN_W   = 16;
   localparam int RATE_W   = 16;
   localparam int PERIOD_W = 4;

   // Shared multiplier operands
   localparam int MUL_A_W = 16;
   localparam int MUL_B_W = 24;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Shared divider widths
   localparam int DIV_N_W = 32;
   localparam int DIV_D_W = 16;
   localparam int DIV_C_W = $clog2(DIV_N_W + 1);

   // Register indexes
   localparam logic REG_PERIOD = 1'b0;
   localparam logic REG_RATE   = 1'b1;

   // Item kinds on tuser
   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_R,
      ST_MUL_G,
      ST_MUL_B,
      ST_LUMA_ADD,
      ST_SUM,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_STEP,
      ST_LIMIT,
      ST_SCALE_GO,
      ST_SCALE_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/lrl_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrl_mul
// Shared registered multiplier for luma terms and the rise step.
// ----------------------------------------------------------------------------
module lrl_mul (
   input  logic                        clock,
   input  logic [lrl_pkg::MUL_A_W-1:0] mul_a,
   input  logic [lrl_pkg::MUL_B_W-1:0] mul_b,
   output logic [lrl_pkg::MUL_P_W-1:0] product
);

   logic [lrl_pkg::MUL_P_W-1:0] product_ff;
   logic [lrl_pkg::MUL_P_W-1:0] product_in;

   assign product_in = lrl_pkg::MUL_P_W'(mul_a) * lrl_pkg::MUL_P_W'(mul_b);
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

FILE: rtl/lrl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrl_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrl_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lrl_pkg::div_req_type div_req,
   output lrl_pkg::div_rsp_type div_rsp
);

   logic [lrl_pkg::DIV_N_W-1:0] quo_ff, quo_in;
   logic [lrl_pkg::DIV_D_W-1:0] rem_ff, rem_in;
   logic [lrl_pkg::DIV_D_W-1:0] den_ff, den_in;
   logic [lrl_pkg::DIV_C_W-1:0] cnt_ff, cnt_in;
   logic                        done_ff, done_in;
   logic [lrl_pkg::DIV_D_W:0]   trial;
   logic [lrl_pkg::DIV_D_W:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[lrl_pkg::DIV_N_W-1]};
      diff    = trial - {1'b0, den_ff};
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         den_in = div_req.divisor;
         cnt_in = lrl_pkg::DIV_C_W'(lrl_pkg::DIV_N_W);
      end else if (cnt_ff != '0) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[lrl_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[lrl_pkg::DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[lrl_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[lrl_pkg::DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == lrl_pkg::DIV_C_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = (cnt_ff != '0);
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: rtl/luma_rise_rate_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luma_rise_rate_limiter_top
// Brightness rise limiter: frame ticks, per-measurement luma mean, scale out.
// ----------------------------------------------------------------------------
// Frame tick: result item valid the cycle after acceptance.
// Pixel sample: three passes through the shared multiplier, then LUMA_ADD and SUM.
// Last sample: the result item follows two 32-step passes of the shared divider
// (mean, then scale) and one multiplier pass for the rise step; a zero mean
// skips the scale division. No new item is taken until the block is idle again.
// Reset clears the control state at once; no clearing pass.
module luma_rise_rate_limiter_top #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: frame_dt[19:0], red[35:20], green[51:36], blue[67:52], zero pad
   input  logic [71:0] req_tdata,
   // tuser: req_type
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: brightness_scale[16:0], zero pad
   output logic [23:0] rsp_tdata,
   // tuser: sample_request[0], scale_updated[1]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = lrl_pkg::COLOR_W + CNT_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

   lrl_pkg::state_type state_ff, state_in;

   logic [lrl_pkg::PERIOD_W-1:0] period_ff;
   logic [lrl_pkg::RATE_W-1:0]   rate_ff;

   logic [lrl_pkg::TIME_W-1:0]   time_ff, time_in;
   logic [lrl_pkg::PERIOD_W-1:0] phase_ff, phase_in;
   logic [lrl_pkg::SCALE_W-1:0]  held_ff, held_in;
   logic [lrl_pkg::MEAN_W-1:0]   tracked_ff, tracked_in;
   logic                         mvalid_ff, mvalid_in;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         await_ff, await_in;

   logic [lrl_pkg::COLOR_W-1:0]  red_ff, red_in;
   logic [lrl_pkg::COLOR_W-1:0]  green_ff, green_in;
   logic [lrl_pkg::COLOR_W-1:0]  blue_ff, blue_in;
   logic                         last_ff, last_in;
   logic [32:0]                  acc_ff, acc_in;
   logic [lrl_pkg::MEAN_W-1:0]   mean_ff, mean_in;
   logic [lrl_pkg::MEAN_W-1:0]   limited_ff, limited_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lrl_pkg::SCALE_W-1:0]  rsp_scale_ff, rsp_scale_in;
   logic                         rsp_req_ff, rsp_req_in;
   logic                         rsp_upd_ff, rsp_upd_in;

   logic [lrl_pkg::MUL_A_W-1:0]  mul_a;
   logic [lrl_pkg::MUL_B_W-1:0]  mul_b;
   logic [lrl_pkg::MUL_P_W-1:0]  product;

   lrl_pkg::div_req_type         div_req;
   lrl_pkg::div_rsp_type         div_rsp;

   logic                         req_accept;
   logic                         cfg_write;
   logic [lrl_pkg::TIME_W:0]     time_sum;
   logic [lrl_pkg::PERIOD_W:0]   period_eff;
   logic [lrl_pkg::PERIOD_W:0]   phase_next;
   logic [lrl_pkg::TIME_W-1:0]   step;
   logic [lrl_pkg::MEAN_W-1:0]   base;
   logic [lrl_pkg::TIME_W:0]     limit;
   logic [lrl_pkg::MEAN_W-1:0]   limited;
   logic [CNT_W-1:0]             cnt_div;
   logic [lrl_pkg::SCALE_W-1:0]  scale;

   lrl_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   lrl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Configuration port
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == lrl_pkg::REG_RATE) ? {16'd0, rate_ff}
                                                           : {28'd0, period_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 4'd3;
         rate_ff   <= 16'd8192;
      end else if (cfg_write) begin
         if (csr_paddr[2] == lrl_pkg::REG_RATE) begin
            rate_ff <= csr_pwdata[15:0];
         end else begin
            period_ff <= csr_pwdata[3:0];
         end
      end
   end

   assign req_tready = (state_ff == lrl_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid & req_tready;

   // Tick arithmetic
   assign time_sum   = {1'b0, time_ff} + (lrl_pkg::TIME_W + 1)'(req_tdata[19:0]);
   assign period_eff = (period_ff == '0) ? 5'd1 : {1'b0, period_ff};
   assign phase_next = {1'b0, phase_ff} + 5'd1;

   // Rise limit arithmetic
   assign step    = product[lrl_pkg::MUL_P_W-1:16];
   assign base    = mvalid_ff ? tracked_ff : mean_ff;
   assign limit   = {1'b0, step} + (lrl_pkg::TIME_W + 1)'(base);
   assign limited = ((lrl_pkg::TIME_W + 1)'(mean_ff) > limit) ? limit[15:0] : mean_ff;
   assign cnt_div = (cnt_ff == '0) ? CNT_W'(1) : cnt_ff;

   always_comb begin
      if (mean_ff == '0) begin
         scale = lrl_pkg::ONE_Q16;
      end else if (div_rsp.quotient > 32'(lrl_pkg::ONE_Q16)) begin
         scale = lrl_pkg::ONE_Q16;
      end else begin
         scale = div_rsp.quotient[lrl_pkg::SCALE_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      phase_in     = phase_ff;
      held_in      = held_ff;
      tracked_in   = tracked_ff;
      mvalid_in    = mvalid_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      await_in     = await_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      mean_in      = mean_ff;
      limited_in   = limited_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_scale_in = rsp_scale_ff;
      rsp_req_in   = rsp_req_ff;
      rsp_upd_in   = rsp_upd_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;

      unique case (state_ff)
         lrl_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == lrl_pkg::KIND_TICK) begin
                  time_in  = time_sum[lrl_pkg::TIME_W] ? '1
                                                       : time_sum[lrl_pkg::TIME_W-1:0];
                  // drop any unfinished measurement
                  sum_in   = '0;
                  cnt_in   = '0;
                  await_in = 1'b0;
                  if (phase_next >= period_eff) begin
                     phase_in = '0;
                     await_in = 1'b1;
                  end else begin
                     phase_in = phase_next[lrl_pkg::PERIOD_W-1:0];
                  end
                  rsp_valid_in = 1'b1;
                  rsp_scale_in = held_ff;
                  rsp_req_in   = (phase_next >= period_eff);
                  rsp_upd_in   = 1'b0;
               end else if (await_ff) begin
                  red_in   = req_tdata[35:20];
                  green_in = req_tdata[51:36];
                  blue_in  = req_tdata[67:52];
                  last_in  = req_tlast;
                  if (cnt_ff < MAX_CNT) begin
                     state_in = lrl_pkg::ST_MUL_R;
                  end else if (req_tlast) begin
                     state_in = lrl_pkg::ST_MEAN_GO;
                  end
               end
            end
         end
         lrl_pkg::ST_MUL_R: begin
            mul_a    = lrl_pkg::W_RED;
            mul_b    = lrl_pkg::MUL_B_W'(red_ff);
            state_in = lrl_pkg::ST_MUL_G;
         end
         lrl_pkg::ST_MUL_G: begin
            acc_in   = lrl_pkg::LUMA_ROUND + 33'(product);
            mul_a    = lrl_pkg::W_GREEN;
            mul_b    = lrl_pkg::MUL_B_W'(green_ff);
            state_in = lrl_pkg::ST_MUL_B;
         end
         lrl_pkg::ST_MUL_B: begin
            acc_in   = acc_ff + 33'(product);
            mul_a    = lrl_pkg::W_BLUE;
            mul_b    = lrl_pkg::MUL_B_W'(blue_ff);
            state_in = lrl_pkg::ST_LUMA_ADD;
         end
         lrl_pkg::ST_LUMA_ADD: begin
            acc_in   = acc_ff + 33'(product);
            state_in = lrl_pkg::ST_SUM;
         end
         lrl_pkg::ST_SUM: begin
            sum_in   = sum_ff + SUM_W'(acc_ff[32:16]);
            cnt_in   = cnt_ff + 1'b1;
            state_in = last_ff ? lrl_pkg::ST_MEAN_GO : lrl_pkg::ST_IDLE;
         end
         lrl_pkg::ST_MEAN_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = lrl_pkg::DIV_N_W'(sum_ff) + lrl_pkg::DIV_N_W'(cnt_div >> 1);
            div_req.divisor  = lrl_pkg::DIV_D_W'(cnt_div);
            state_in         = lrl_pkg::ST_MEAN_WAIT;
         end
         lrl_pkg::ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               mean_in  = (div_rsp.quotient[31:16] != '0) ? 16'hFFFF
                                                          : div_rsp.quotient[15:0];
               state_in = lrl_pkg::ST_STEP;
            end
         end
         lrl_pkg::ST_STEP: begin
            mul_a    = rate_ff;
            mul_b    = time_ff;
            state_in = lrl_pkg::ST_LIMIT;
         end
         lrl_pkg::ST_LIMIT: begin
            limited_in = limited;
            tracked_in = (mean_ff < base) ? mean_ff : limited;
            mvalid_in  = 1'b1;
            state_in   = (mean_ff == '0) ? lrl_pkg::ST_FINISH : lrl_pkg::ST_SCALE_GO;
         end
         lrl_pkg::ST_SCALE_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {limited_ff, 16'd0};
            div_req.divisor  = mean_ff;
            state_in         = lrl_pkg::ST_SCALE_WAIT;
         end
         lrl_pkg::ST_SCALE_WAIT: begin
            if (div_rsp.done) begin
               state_in = lrl_pkg::ST_FINISH;
            end
         end
         lrl_pkg::ST_FINISH: begin
            held_in      = scale;
            rsp_valid_in = 1'b1;
            rsp_scale_in = scale;
            rsp_req_in   = 1'b0;
            rsp_upd_in   = 1'b1;
            time_in      = '0;
            await_in     = 1'b0;
            sum_in       = '0;
            cnt_in       = '0;
            state_in     = lrl_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrl_pkg::ST_IDLE;
         time_ff      <= '0;
         phase_ff     <= '0;
         held_ff      <= lrl_pkg::ONE_Q16;
         tracked_ff   <= '0;
         mvalid_ff    <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         await_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         tracked_ff   <= tracked_in;
         mvalid_ff    <= mvalid_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         await_ff     <= await_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      last_ff      <= last_in;
      acc_ff       <= acc_in;
      mean_ff      <= mean_in;
      limited_ff   <= limited_in;
      rsp_scale_ff <= rsp_scale_in;
      rsp_req_ff   <= rsp_req_in;
      rsp_upd_ff   <= rsp_upd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_scale_ff};
   assign rsp_tuser  = {rsp_upd_ff, rsp_req_ff};

`ifndef NO_ASSERTIONS
   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lrl_pkg::ST_FINISH) |-> !rsp_valid_ff)
      else $error("measurement result would overwrite a pending item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("sample count past limit");

   a_scale_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= lrl_pkg::ONE_Q16)
      else $error("held scale above one");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == lrl_pkg::KIND_TICK) |=> (rsp_valid_ff && !rsp_upd_ff))
      else $error("tick gave no result item");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the luma rise rate limiter: random frame ticks and
// pixel sample bursts go in on the request stream, and every result item is
// checked against a cycle-free model of scale, request and update flags.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SAMPLES_MAX = 64;
   localparam int SETTLE_CYCLES = 150;

   typedef struct packed {
      logic                     kind;
      logic [lrl_pkg::DT_W-1:0] dt;
      logic [15:0]              red;
      logic [15:0]              green;
      logic [15:0]              blue;
      logic                     last;
   } luma_item_type;

   typedef struct packed {
      logic [lrl_pkg::SCALE_W-1:0] scale;
      logic                        request;
      logic                        updated;
   } scale_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   luma_rise_rate_limiter_top #(.MAX_SAMPLES(SAMPLES_MAX)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // stimulus and expectations
   luma_item_type    luma_items[$];
   scale_result_type scale_results_due[$];
   luma_item_type    item_on_bus;
   bit               stall_on = 1'b1;
   int               req_gap = 0;
   int               rsp_gap = 0;
   int               mismatches = 0;
   int               ticks_checked = 0;
   int               measures_checked = 0;
   int               settings_used = 0;
   logic [3:0]       gen_phase = '0;

   // model copy of configuration and state
   logic [lrl_pkg::PERIOD_W-1:0] cfg_period = 4'd3;
   logic [lrl_pkg::RATE_W-1:0]   cfg_rate = 16'd8192;
   logic [lrl_pkg::TIME_W-1:0]   acc_time = '0;
   logic [3:0]                   phase = '0;
   logic [lrl_pkg::SCALE_W-1:0]  held_scale = lrl_pkg::ONE_Q16;
   logic [lrl_pkg::MEAN_W-1:0]   tracked = '0;
   logic                         tracked_ok = 1'b0;
   logic [21:0]                  lsum = '0;
   logic [6:0]                   scount = '0;
   logic                         awaiting = 1'b0;

   function automatic logic [15:0] luma_of_rgb(logic [15:0] r, logic [15:0] g,
                                               logic [15:0] b);
      logic [33:0] weighted;
      weighted = lrl_pkg::W_RED * r + lrl_pkg::W_GREEN * g + lrl_pkg::W_BLUE * b
               + lrl_pkg::LUMA_ROUND;
      return weighted[31:16];
   endfunction

   function automatic logic [lrl_pkg::SCALE_W-1:0] close_measurement();
      logic [7:0]  cnt;
      logic [31:0] mean_full;
      logic [15:0] mean;
      logic [39:0] product;
      logic [23:0] rise;
      logic [24:0] limit;
      logic [15:0] limited;
      logic [32:0] quot;
      logic [lrl_pkg::SCALE_W-1:0] scale;
      cnt = (scount == 0) ? 8'd1 : {1'b0, scount};
      mean_full = (lsum + cnt / 2) / cnt;
      mean = (mean_full > 32'hFFFF) ? 16'hFFFF : mean_full[15:0];
      if (!tracked_ok) begin
         tracked = mean;
         tracked_ok = 1'b1;
      end
      product = cfg_rate * acc_time;
      rise = product[39:16];
      limit = tracked + rise;
      limited = ({9'd0, mean} > limit) ? limit[15:0] : mean;
      if (mean == 0) begin
         scale = lrl_pkg::ONE_Q16;
      end else begin
         quot = {limited, 16'd0} / mean;
         scale = (quot > lrl_pkg::ONE_Q16) ? lrl_pkg::ONE_Q16 : quot[lrl_pkg::SCALE_W-1:0];
      end
      tracked = (mean < tracked) ? mean : limited;
      held_scale = scale;
      acc_time = '0;
      awaiting = 1'b0;
      lsum = '0;
      scount = '0;
      return scale;
   endfunction

   function automatic void limiter_advance(luma_item_type it);
      logic [lrl_pkg::TIME_W:0] acc_next;
      logic [4:0]               per;
      scale_result_type         res;
      if (it.kind == lrl_pkg::KIND_TICK) begin
         acc_next = acc_time + it.dt;
         acc_time = (acc_next > 25'hFFFFFF) ? 24'hFFFFFF : acc_next[lrl_pkg::TIME_W-1:0];
         awaiting = 1'b0;
         lsum = '0;
         scount = '0;
         per = (cfg_period == 0) ? 5'd1 : {1'b0, cfg_period};
         res.request = 1'b0;
         if ({1'b0, phase} + 5'd1 >= per) begin
            phase = '0;
            res.request = 1'b1;
            awaiting = 1'b1;
         end else begin
            phase = phase + 4'd1;
         end
         res.scale = held_scale;
         res.updated = 1'b0;
         scale_results_due.push_back(res);
      end else if (awaiting) begin
         if (scount < SAMPLES_MAX) begin
            lsum = lsum + luma_of_rgb(it.red, it.green, it.blue);
            scount = scount + 7'd1;
         end
         if (it.last) begin
            res.scale = close_measurement();
            res.request = 1'b0;
            res.updated = 1'b1;
            scale_results_due.push_back(res);
         end
      end
   endfunction

   // Queue a frame tick; report whether the block will ask for samples.
   function automatic bit add_tick(logic [lrl_pkg::DT_W-1:0] dt);
      luma_item_type it;
      logic [4:0]    per;
      it.kind = lrl_pkg::KIND_TICK;
      it.dt = dt;
      it.red = 16'($urandom);
      it.green = 16'($urandom);
      it.blue = 16'($urandom);
      it.last = 1'($urandom_range(0, 1));
      luma_items.push_back(it);
      per = (cfg_period == 0) ? 5'd1 : {1'b0, cfg_period};
      if ({1'b0, gen_phase} + 5'd1 >= per) begin
         gen_phase = '0;
         return 1'b1;
      end
      gen_phase = gen_phase + 4'd1;
      return 1'b0;
   endfunction

   function automatic void add_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                     logic last);
      luma_item_type it;
      it.kind = lrl_pkg::KIND_SAMPLE;
      it.dt = lrl_pkg::DT_W'($urandom);
      it.red = r;
      it.green = g;
      it.blue = b;
      it.last = last;
      luma_items.push_back(it);
   endfunction

   function automatic logic [lrl_pkg::DT_W-1:0] pick_dt();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return lrl_pkg::DT_W'(1092 + $urandom_range(0, 64) - 32);
      if (pick < 8) return lrl_pkg::DT_W'($urandom);
      if (pick < 9) return lrl_pkg::DT_W'($urandom_range(0, 50));
      return 20'hFFFFF;
   endfunction

   function automatic logic [15:0] pick_chan(int mode, int level);
      int v;
      case (mode)
         0: return 16'($urandom);
         1: begin
            v = level + $urandom_range(0, 255);
            return (v > 65535) ? 16'hFFFF : 16'(v);
         end
         2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic int add_burst(bit closed);
      int len;
      int mode;
      int level;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      mode = $urandom_range(0, 3);
      level = $urandom_range(0, 65535);
      for (int k = 0; k < len; k++) begin
         add_pixel(pick_chan(mode, level), pick_chan(mode, level), pick_chan(mode, level),
                   closed && (k == len - 1));
      end
      return len;
   endfunction

   function automatic void fill_random(int target);
      int counted;
      int pick;
      bit wants;
      counted = 0;
      while (counted < target) begin
         if ($urandom_range(0, 99) < 3) begin
            // long silence: run the time accumulator into saturation
            for (int k = 0; k < 18; k++) void'(add_tick(20'hFFFFF));
            counted += 18;
         end
         wants = add_tick(pick_dt());
         counted++;
         pick = $urandom_range(0, 99);
         if (wants) begin
            if (pick < 82) counted += add_burst(1'b1);
            else if (pick < 92) counted += add_burst(1'b0);
         end else if (pick < 10) begin
            // stray samples, dropped by the block
            for (int k = 0; k < $urandom_range(1, 2); k++)
               add_pixel(16'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom_range(0, 1)));
         end
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) limiter_advance(item_on_bus);
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
               req_gap <= $urandom_range(0, 8);
               req_tvalid <= 1'b0;
            end else if (luma_items.size() != 0) begin
               item_on_bus = luma_items.pop_front();
               req_tdata <= {4'd0, item_on_bus.blue, item_on_bus.green, item_on_bus.red,
                             item_on_bus.dt};
               req_tuser <= item_on_bus.kind;
               req_tlast <= item_on_bus.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      scale_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (scale_results_due.size() == 0) begin
               $display("%0t: unexpected result item, expected none, got scale %0d flags %b",
                        $time, rsp_tdata[lrl_pkg::SCALE_W-1:0], rsp_tuser);
               mismatches++;
            end else begin
               want = scale_results_due.pop_front();
               if (want.updated) measures_checked++;
               else ticks_checked++;
               if (rsp_tdata[lrl_pkg::SCALE_W-1:0] !== want.scale) begin
                  $display("%0t: brightness_scale mismatch, expected %0d, got %0d",
                           $time, want.scale, rsp_tdata[lrl_pkg::SCALE_W-1:0]);
                  mismatches++;
               end
               if (rsp_tuser[0] !== want.request) begin
                  $display("%0t: sample_request mismatch, expected %b, got %b",
                           $time, want.request, rsp_tuser[0]);
                  mismatches++;
               end
               if (rsp_tuser[1] !== want.updated) begin
                  $display("%0t: scale_updated mismatch, expected %b, got %b",
                           $time, want.updated, rsp_tuser[1]);
                  mismatches++;
               end
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_gap <= $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Write one register, then read it back.
   task automatic write_reg(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == lrl_pkg::REG_PERIOD) cfg_period = value[lrl_pkg::PERIOD_W-1:0];
      else cfg_rate = value[lrl_pkg::RATE_W-1:0];
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) begin
         $display("%0t: register %0d readback mismatch, expected %0h, got %0h",
                  $time, idx, value, csr_prdata);
         mismatches++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drain all items and results, then give the block time to go idle.
   task automatic settle();
      while (luma_items.size() != 0 || req_tvalid || scale_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   logic [lrl_pkg::PERIOD_W-1:0] period_plan[8];
   logic [lrl_pkg::RATE_W-1:0]   rate_plan[8];

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: period 3, rate 8192 per second
      add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      void'(add_tick(20'd0));
      void'(add_tick(20'hFFFFF));
      void'(add_tick(20'hFFFFF));
      add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      add_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
      void'(add_tick(20'd1092));
      void'(add_tick(20'd1092));
      void'(add_tick(20'd1092));
      add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      void'(add_tick(20'd1092));
      void'(add_tick(20'd1092));
      void'(add_tick(20'd1092));
      add_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
      void'(add_tick(20'd1092));
      void'(add_tick(20'd1092));
      void'(add_tick(20'd1092));
      add_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      void'(add_tick(20'd500));
      add_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b1);
      void'(add_tick(20'd1092));
      void'(add_tick(20'd1092));
      add_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
      add_pixel(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
      settle();

      period_plan = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd1, 4'd4, 4'd1, 4'd1};
      rate_plan = '{16'd8192, 16'hFFFF, 16'd0, 16'd100, 16'd0, 16'hFFFF, 16'd8192, 16'd8192};
      period_plan[6] = 4'($urandom_range(1, 15));
      rate_plan[3] = 16'($urandom);
      rate_plan[6] = 16'($urandom);
      rate_plan[7] = 16'($urandom);

      foreach (period_plan[p]) begin
         write_reg(lrl_pkg::REG_PERIOD, {28'd0, period_plan[p]});
         write_reg(lrl_pkg::REG_RATE, {16'd0, rate_plan[p]});
         settings_used++;
         // no idling on the last stretch
         if (p == 7) stall_on = 1'b0;
         fill_random(180);
         settle();
      end

      $display("Checked %0d tick results and %0d measurement results over %0d settings",
               ticks_checked, measures_checked, settings_used + 1);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timeout waiting for result items");
      $display("Some tests failed");
      $finish;
   end

endmodule
